// ===== rtl/piv_pkg.sv =====
// ----------------------------------------------------------------------------
// Parabolic inlet velocity: shared types and constants
// Register map, configuration bundle and the payload structs that pass
// between the pipeline sections.
// ----------------------------------------------------------------------------
package piv_pkg;

   // Width of the register index on the configuration port.
   localparam int CsrIndexW = 4;

   // Fraction bits of the Q2.14 normal components.
   localparam int NormFracW = 14;

   // Reset values of the registers that do not clear to zero.
   localparam logic [15:0] NormalXReset   = 16'd16384;
   localparam logic [31:0] InvRadiusReset = 32'd65536;

   // Register indexes on the configuration port.
   typedef enum logic [CsrIndexW-1:0] {
      CSR_NORMAL_X      = 4'd0,
      CSR_NORMAL_Y      = 4'd1,
      CSR_NORMAL_Z      = 4'd2,
      CSR_CENTER_X      = 4'd3,
      CSR_CENTER_Y      = 4'd4,
      CSR_CENTER_Z      = 4'd5,
      CSR_INV_RADIUS_SQ = 4'd6,
      CSR_PEAK_SPEED    = 4'd7
   } csr_index_type;

   // Live configuration: normal (Q2.14), centre (Q16.16), 1/r^2, peak speed.
   typedef struct packed {
      logic [2:0][15:0] normal;
      logic [2:0][31:0] center;
      logic [31:0]      inv_radius_sq;
      logic [30:0]      peak_speed;
   } cfg_type;

   // Distance section result: per-axis magnitude and a far-away flag.
   typedef struct packed {
      logic [2:0][30:0] mag;
      logic             far;
   } dist_type;

   // Ratio section result: profile fraction (Q.32, at most 1.0) and inside flag.
   typedef struct packed {
      logic [32:0] frac;
      logic        in_radius;
   } ratio_type;

endpackage

// ===== rtl/piv_csr.sv =====
// ----------------------------------------------------------------------------
// Parabolic inlet velocity: configuration registers
// Holds the inlet normal, centre, inverse squared radius and peak speed.
// ----------------------------------------------------------------------------
module piv_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [piv_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [31:0]                    csr_data,
   output piv_pkg::cfg_type               cfg
);
   import piv_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; unknown indexes leave everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_NORMAL_X:      cfg_in.normal[0]     = csr_data[15:0];
            CSR_NORMAL_Y:      cfg_in.normal[1]     = csr_data[15:0];
            CSR_NORMAL_Z:      cfg_in.normal[2]     = csr_data[15:0];
            CSR_CENTER_X:      cfg_in.center[0]     = csr_data;
            CSR_CENTER_Y:      cfg_in.center[1]     = csr_data;
            CSR_CENTER_Z:      cfg_in.center[2]     = csr_data;
            CSR_INV_RADIUS_SQ: cfg_in.inv_radius_sq = csr_data;
            CSR_PEAK_SPEED:    cfg_in.peak_speed    = csr_data[30:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Register file with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal        <= {16'd0, 16'd0, NormalXReset};
         cfg_ff.center        <= '0;
         cfg_ff.inv_radius_sq <= InvRadiusReset;
         cfg_ff.peak_speed    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/piv_dist.sv =====
// ----------------------------------------------------------------------------
// Parabolic inlet velocity: distance section
// Five stages: projection products, dot product, reference point products,
// offset from the reference point, and magnitude with a far-away flag.
// ----------------------------------------------------------------------------
module piv_dist (
   input  logic                 clock,
   input  logic                 reset,
   input  piv_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [31:0]   pos_x,
   input  logic signed [31:0]   pos_y,
   input  logic signed [31:0]   pos_z,
   output logic                 out_valid,
   input  logic                 out_ready,
   output piv_pkg::dist_type    out_data
);
   import piv_pkg::*;

   localparam int NStage = 5;

   logic [NStage-1:0] vld_ff;
   logic [NStage-1:0] en;

   logic signed [31:0] pos     [3];
   logic signed [47:0] pn1_in  [3];
   logic signed [49:0] cn1_in  [3];
   logic signed [17:0] one_n   [3];
   logic signed [49:0] dot_sum;
   logic signed [51:0] dn3_in  [3];
   logic signed [53:0] diff    [3];
   logic        [39:0] mag     [3];
   logic               far5_in;

   logic signed [31:0] pos1_ff [3];
   logic signed [47:0] pn1_ff  [3];
   logic signed [49:0] cn1_ff  [3];
   logic signed [31:0] pos2_ff [3];
   logic signed [49:0] cn2_ff  [3];
   logic signed [35:0] dot2_ff;
   logic signed [31:0] pos3_ff [3];
   logic signed [49:0] cn3_ff  [3];
   logic signed [51:0] dn3_ff  [3];
   logic signed [39:0] d4_ff   [3];
   logic        [30:0] mag5_ff [3];
   logic               far5_ff;

   assign pos[0] = pos_x;
   assign pos[1] = pos_y;
   assign pos[2] = pos_z;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      en[NStage-1] = !vld_ff[NStage-1] || out_ready;
      for (int k = NStage - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NStage-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k < NStage; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Stage 1: p_i * n_i and (1 + n_i) * c_i.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         one_n[i]  = 18'sd16384 + 18'($signed(cfg.normal[i]));
         pn1_in[i] = 48'(pos[i]) * 48'($signed(cfg.normal[i]));
         cn1_in[i] = 50'(one_n[i]) * 50'($signed(cfg.center[i]));
      end
   end

   // Stage 2: dot product, floored to Q.16.
   assign dot_sum = 50'(pn1_ff[0]) + 50'(pn1_ff[1]) + 50'(pn1_ff[2]);

   // Stage 3: dot * n_i, the projected part of the reference point.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dn3_in[i] = 52'(dot2_ff) * 52'($signed(cfg.normal[i]));
      end
   end

   // Stage 4: offset from the reference point in Q.30, floored to Q.16.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = (54'(pos3_ff[i]) <<< NormFracW) - 54'(cn3_ff[i]) - 54'(dn3_ff[i]);
      end
   end

   // Stage 5: magnitude per axis; anything at 2^31 or above is far away.
   always_comb begin
      far5_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag[i]  = d4_ff[i][39] ? 40'(-d4_ff[i]) : 40'(d4_ff[i]);
         far5_in = far5_in || (|mag[i][39:31]);
      end
   end

   // Data registers of all stages.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            pos1_ff[i] <= pos[i];
            pn1_ff[i]  <= pn1_in[i];
            cn1_ff[i]  <= cn1_in[i];
         end
      end
      if (en[1]) begin
         dot2_ff <= dot_sum[49:14];
         for (int i = 0; i < 3; i++) begin
            pos2_ff[i] <= pos1_ff[i];
            cn2_ff[i]  <= cn1_ff[i];
         end
      end
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            pos3_ff[i] <= pos2_ff[i];
            cn3_ff[i]  <= cn2_ff[i];
            dn3_ff[i]  <= dn3_in[i];
         end
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            d4_ff[i] <= diff[i][53:14];
         end
      end
      if (en[4]) begin
         far5_ff <= far5_in;
         for (int i = 0; i < 3; i++) begin
            mag5_ff[i] <= mag[i][30:0];
         end
      end
   end

   assign out_data.mag  = {mag5_ff[2], mag5_ff[1], mag5_ff[0]};
   assign out_data.far  = far5_ff;

endmodule

// ===== rtl/piv_ratio.sv =====
// ----------------------------------------------------------------------------
// Parabolic inlet velocity: ratio section
// Five stages: squares, squared distance, product with 1/r^2 in two halves,
// recombination, then the inside test and the profile fraction 1 - q.
// ----------------------------------------------------------------------------
module piv_ratio (
   input  logic                 clock,
   input  logic                 reset,
   input  piv_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  piv_pkg::dist_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output piv_pkg::ratio_type   out_data
);
   import piv_pkg::*;

   localparam int NStage = 5;
   localparam logic [63:0] OneQ16  = 64'd65536;
   localparam logic [48:0] OneQ48  = 49'h1_0000_0000_0000;

   logic [NStage-1:0] vld_ff;
   logic [NStage-1:0] en;

   logic [61:0] sq1_in [3];
   logic [61:0] sq1_ff [3];
   logic        far1_ff;
   logic [63:0] d2_ff;
   logic        far2_ff;
   logic [63:0] lo3_ff;
   logic [63:0] hi3_ff;
   logic        far3_ff;
   logic [63:0] t4_ff;
   logic [31:0] low4_ff;
   logic        far4_ff;
   logic [32:0] frac5_ff;
   logic        inside5_ff;

   logic        q_le_one;
   logic        inside5_in;
   logic [48:0] q48;
   logic [48:0] rest;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      en[NStage-1] = !vld_ff[NStage-1] || out_ready;
      for (int k = NStage - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NStage-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k < NStage; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Stage 1: square of each axis magnitude.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq1_in[i] = 62'(in_data.mag[i]) * 62'(in_data.mag[i]);
      end
   end

   // Stage 5: q = {t, low} in Q.48; inside when q <= 1.0. A zero inverse
   // radius makes q zero, so the particle is inside even when far away.
   assign q_le_one   = (t4_ff < OneQ16) || ((t4_ff == OneQ16) && (low4_ff == '0));
   assign inside5_in = q_le_one && (!far4_ff || (cfg.inv_radius_sq == '0));
   assign q48        = {t4_ff[16:0], low4_ff};
   assign rest       = OneQ48 - q48;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         far1_ff <= in_data.far;
         for (int i = 0; i < 3; i++) begin
            sq1_ff[i] <= sq1_in[i];
         end
      end
      if (en[1]) begin
         far2_ff <= far1_ff;
         d2_ff   <= 64'(sq1_ff[0]) + 64'(sq1_ff[1]) + 64'(sq1_ff[2]);
      end
      if (en[2]) begin
         far3_ff <= far2_ff;
         lo3_ff  <= 64'(d2_ff[31:0])  * 64'(cfg.inv_radius_sq);
         hi3_ff  <= 64'(d2_ff[63:32]) * 64'(cfg.inv_radius_sq);
      end
      if (en[3]) begin
         far4_ff <= far3_ff;
         t4_ff   <= hi3_ff + 64'(lo3_ff[63:32]);
         low4_ff <= lo3_ff[31:0];
      end
      if (en[4]) begin
         inside5_ff <= inside5_in;
         frac5_ff   <= inside5_in ? rest[48:16] : '0;
      end
   end

   assign out_data.frac      = frac5_ff;
   assign out_data.in_radius = inside5_ff;

endmodule

// ===== rtl/piv_speed.sv =====
// ----------------------------------------------------------------------------
// Parabolic inlet velocity: speed section
// Three stages: profile speed, scaling by the normal, then negation, floor
// to Q.16 and saturation into the result register.
// ----------------------------------------------------------------------------
module piv_speed (
   input  logic                 clock,
   input  logic                 reset,
   input  piv_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  piv_pkg::ratio_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [31:0]   vel_x,
   output logic signed [31:0]   vel_y,
   output logic signed [31:0]   vel_z,
   output logic                 inside_radius
);
   import piv_pkg::*;

   localparam int NStage = 3;

   logic [NStage-1:0] vld_ff;
   logic [NStage-1:0] en;

   logic        [63:0] prod;
   logic        [30:0] s1_ff;
   logic               inside1_ff;
   logic signed [46:0] ns2_in  [3];
   logic signed [46:0] ns2_ff  [3];
   logic               inside2_ff;
   logic signed [47:0] neg     [3];
   logic signed [33:0] shr     [3];
   logic signed [31:0] vel_in  [3];
   logic signed [31:0] vel_ff  [3];
   logic               inside3_ff;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      en[NStage-1] = !vld_ff[NStage-1] || out_ready;
      for (int k = NStage - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NStage-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k < NStage; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Stage 1: speed = peak * fraction, fraction being Q.32.
   assign prod = 64'(cfg.peak_speed) * 64'(in_data.frac);

   // Stage 2: n_i * speed.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ns2_in[i] = 47'($signed(cfg.normal[i])) * 47'($signed({1'b0, s1_ff}));
      end
   end

   // Stage 3: negate, floor to Q.16 and clamp to the signed 32-bit range.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg[i] = -48'(ns2_ff[i]);
         shr[i] = neg[i][47:14];
         if ((shr[i][33:31] == 3'b000) || (shr[i][33:31] == 3'b111)) begin
            vel_in[i] = shr[i][31:0];
         end else if (shr[i][33]) begin
            vel_in[i] = 32'sh8000_0000;
         end else begin
            vel_in[i] = 32'sh7fff_ffff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff      <= prod[62:32];
         inside1_ff <= in_data.in_radius;
      end
      if (en[1]) begin
         inside2_ff <= inside1_ff;
         for (int i = 0; i < 3; i++) begin
            ns2_ff[i] <= ns2_in[i];
         end
      end
      if (en[2]) begin
         inside3_ff <= inside2_ff;
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= vel_in[i];
         end
      end
   end

   assign vel_x         = vel_ff[0];
   assign vel_y         = vel_ff[1];
   assign vel_z         = vel_ff[2];
   assign inside_radius = inside3_ff;

endmodule

// ===== rtl/parabolic_inlet_velocity.sv =====
// ----------------------------------------------------------------------------
// Parabolic inlet velocity
// Poiseuille inlet profile: one particle position in, one velocity out.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the req_ channel carries a particle position (Q16.16). The
//   block answers each request with one result on the rsp_ channel: the
//   inlet velocity vector (Q16.16, saturated) and an inside-radius flag.
//   Results leave in request order.
//   The pipeline holds 13 register stages between a request being taken
//   and its result on the rsp_ channel.
//   Five stages for the distance to the reference point, five for the
//   squared-distance ratio and three for the speed and the output register.
//   One request can be taken every cycle while req_stall is low; the rate is
//   set by the pipeline, whose stages each pass a request on as they take one.
//   When the receiver holds rsp_stall, finished results wait in place and
//   empty stages keep filling; req_stall rises only once every stage holds a
//   request. Nothing is dropped or repeated.
//   Configuration is written through the csr_ port, which is always ready;
//   write it only while no request is in flight.
//   Synchronous reset empties the pipeline and loads the register defaults:
//   normal (1,0,0), centre at the origin, 1/r^2 of one and zero peak speed.
// ----------------------------------------------------------------------------
module parabolic_inlet_velocity (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_pos_x,
   input  logic signed [31:0]             req_pos_y,
   input  logic signed [31:0]             req_pos_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_vel_x,
   output logic signed [31:0]             rsp_vel_y,
   output logic signed [31:0]             rsp_vel_z,
   output logic                           rsp_inside_radius,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [piv_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [31:0]                    csr_data
);
   import piv_pkg::*;

   cfg_type   cfg;
   dist_type  dist_data;
   ratio_type ratio_data;
   logic      dist_valid;
   logic      dist_ready;
   logic      ratio_valid;
   logic      ratio_ready;
   logic      req_ready;

   // Configuration registers.
   piv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Distance from the reference point.
   piv_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .out_valid (dist_valid),
      .out_ready (dist_ready),
      .out_data  (dist_data)
   );

   // Ratio to the radius and inside test.
   piv_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (dist_valid),
      .in_ready  (dist_ready),
      .in_data   (dist_data),
      .out_valid (ratio_valid),
      .out_ready (ratio_ready),
      .out_data  (ratio_data)
   );

   // Velocity and result register.
   piv_speed u_speed (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (ratio_valid),
      .in_ready      (ratio_ready),
      .in_data       (ratio_data),
      .out_valid     (rsp_valid),
      .out_ready     (!rsp_stall),
      .vel_x         (rsp_vel_x),
      .vel_y         (rsp_vel_y),
      .vel_z         (rsp_vel_z),
      .inside_radius (rsp_inside_radius)
   );

   assign req_stall = !req_ready;

   // The pipeline is empty in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // Requests are refused only when the result is held by the receiver.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && ratio_valid && dist_valid))
      else $error("request refused while the pipeline had room");

   // A particle outside the radius always gets zero velocity.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_radius) |->
      (rsp_vel_x == '0 && rsp_vel_y == '0 && rsp_vel_z == '0))
      else $error("non-zero velocity outside the inlet radius");

   // The profile fraction never exceeds one and is zero outside.
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      ratio_valid |-> (!(ratio_data.frac[32] && (|ratio_data.frac[31:0]))
                       && (ratio_data.in_radius || ratio_data.frac == '0)))
      else $error("profile fraction out of range");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Parabolic inlet velocity: block-level testbench
// Drives particle positions into the inlet block, predicts each velocity
// from a shadow copy of the inlet registers and checks every result in
// order. Covers register defaults, the radius boundary, far particles, a
// zero inverse radius, saturation, ignored register indexes, random inlet
// settings and a long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
   import piv_pkg::*;

   // Pipeline depth in register stages from the block header, and the no-progress limit.
   localparam int PipeLatency = 13;
   localparam int IdleLimit   = 3000;
   localparam int HoldOffLen  = 300;

   typedef struct {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               in_radius;
   } velocity_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [31:0]            req_pos_x;
   logic signed [31:0]            req_pos_y;
   logic signed [31:0]            req_pos_z;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [31:0]            rsp_vel_x;
   logic signed [31:0]            rsp_vel_y;
   logic signed [31:0]            rsp_vel_z;
   logic                          rsp_inside_radius;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CsrIndexW-1:0]          csr_index;
   logic [31:0]                   csr_data;

   // Shadow of the inlet registers used by the velocity predictor.
   logic signed [15:0] inlet_normal [3];
   logic signed [31:0] inlet_center [3];
   logic [31:0]        inlet_inv_radius_sq;
   logic [30:0]        inlet_peak_speed;

   velocity_type velocity_q [$];
   int  error_count;
   int  request_count;
   int  result_count;
   int  inside_count;
   int  write_count;
   int  setting_count;
   int  backpressure_cycles;
   int  idle_cycles;
   int  hold_off_request;
   bit  send_quiet;
   bit  stall_quiet;

   parabolic_inlet_velocity u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vel_x         (rsp_vel_x),
      .rsp_vel_y         (rsp_vel_y),
      .rsp_vel_z         (rsp_vel_z),
      .rsp_inside_radius (rsp_inside_radius),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Velocity that the inlet profile gives for one position, from the shadow.
   function automatic velocity_type predict_velocity(input logic signed [31:0] px,
                                                     input logic signed [31:0] py,
                                                     input logic signed [31:0] pz);
      longint          pos [3];
      longint          nrm [3];
      longint          ctr [3];
      longint          dot16;
      longint          ref_point;
      longint          diff;
      longint          speed;
      longint          vel [3];
      longint unsigned mag [3];
      longint unsigned dist_sq;
      longint unsigned prod_lo;
      longint unsigned prod_hi;
      longint unsigned ratio_hi;
      longint unsigned ratio;
      longint unsigned profile;
      longint unsigned unit_ratio;
      bit              far_away;
      bit              in_radius;
      velocity_type    result;

      pos[0] = px;
      pos[1] = py;
      pos[2] = pz;
      for (int i = 0; i < 3; i++) begin
         nrm[i] = inlet_normal[i];
         ctr[i] = inlet_center[i];
      end

      // Projection of the position on the normal, floored to Q16.16.
      dot16 = (pos[0] * nrm[0] + pos[1] * nrm[1] + pos[2] * nrm[2]) >>> NormFracW;

      // Offset from the reference point, per axis, floored to Q16.16.
      far_away = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ref_point = ((longint'(1) <<< NormFracW) + nrm[i]) * ctr[i] + dot16 * nrm[i];
         diff = ((pos[i] <<< NormFracW) - ref_point) >>> NormFracW;
         mag[i] = (diff < 0) ? -diff : diff;
         if (mag[i] >= (64'd1 << 31)) far_away = 1'b1;
      end

      // Squared distance times the inverse squared radius, compared with one.
      unit_ratio = 64'd1 << 16;
      ratio = 0;
      if (inlet_inv_radius_sq == 0) begin
         in_radius = 1'b1;
      end else if (far_away) begin
         in_radius = 1'b0;
      end else begin
         dist_sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         prod_lo = (dist_sq & 64'hFFFF_FFFF) * inlet_inv_radius_sq;
         prod_hi = (dist_sq >> 32) * inlet_inv_radius_sq;
         ratio_hi = prod_hi + (prod_lo >> 32);
         in_radius = !(ratio_hi > unit_ratio ||
                       (ratio_hi == unit_ratio && prod_lo[31:0] != 0));
         if (in_radius) ratio = (ratio_hi << 32) | prod_lo[31:0];
      end

      // Parabolic speed along the inverted normal, saturated per axis.
      result.in_radius = in_radius;
      if (in_radius) begin
         profile = ((64'd1 << 48) - ratio) >> 16;
         speed = longint'((inlet_peak_speed * profile) >> 32);
         for (int i = 0; i < 3; i++) begin
            vel[i] = (-(nrm[i] * speed)) >>> NormFracW;
            if (vel[i] > 64'sd2147483647) vel[i] = 64'sd2147483647;
            if (vel[i] < -64'sd2147483648) vel[i] = -64'sd2147483648;
         end
         result.vel_x = vel[0][31:0];
         result.vel_y = vel[1][31:0];
         result.vel_z = vel[2][31:0];
      end else begin
         result.vel_x = '0;
         result.vel_y = '0;
         result.vel_z = '0;
      end
      return result;
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] expected,
                              input logic signed [31:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endtask

   // Expected velocities are queued on acceptance and checked in order.
   always @(posedge clock) begin
      velocity_type expected;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (velocity_q.size() == 0) begin
               $error("velocity result with no request outstanding");
               error_count++;
            end else begin
               expected = velocity_q.pop_front();
               if (expected.in_radius) inside_count++;
               check_field("vel_x", expected.vel_x, rsp_vel_x);
               check_field("vel_y", expected.vel_y, rsp_vel_y);
               check_field("vel_z", expected.vel_z, rsp_vel_z);
               check_field("inside_radius", 32'(expected.in_radius),
                           32'(rsp_inside_radius));
            end
         end
         if (req_valid && !req_stall) begin
            request_count++;
            velocity_q.insert(velocity_q.size(),
                              predict_velocity(req_pos_x, req_pos_y, req_pos_z));
         end
         if (req_valid && req_stall) backpressure_cycles++;
      end
   end

   // Watchdog: ends the run when no channel makes progress for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stall phases, quiet stretches and the long hold-off.
   initial begin
      int phase_left;
      int hold_left;
      phase_left = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            phase_left = 0;
            rsp_stall <= 1'b1;
         end else if (stall_quiet) begin
            rsp_stall <= 1'b0;
         end else if (phase_left > 0) begin
            phase_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            phase_left = pick_gap();
         end
      end
   end

   // Offers one position after an optional gap and waits for its acceptance.
   task automatic send_position(input logic signed [31:0] x, input logic signed [31:0] y,
                                input logic signed [31:0] z);
      int gap;
      gap = send_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering and waits until every expected velocity has arrived.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (velocity_q.size() != 0) @(posedge clock);
      repeat (PipeLatency + 4) @(posedge clock);
   endtask

   // One register write; the shadow follows once the write is taken.
   task automatic write_register(input logic [CsrIndexW-1:0] index,
                                 input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      write_count++;
      case (index)
         CSR_NORMAL_X:      inlet_normal[0]     = data[15:0];
         CSR_NORMAL_Y:      inlet_normal[1]     = data[15:0];
         CSR_NORMAL_Z:      inlet_normal[2]     = data[15:0];
         CSR_CENTER_X:      inlet_center[0]     = data;
         CSR_CENTER_Y:      inlet_center[1]     = data;
         CSR_CENTER_Z:      inlet_center[2]     = data;
         CSR_INV_RADIUS_SQ: inlet_inv_radius_sq = data;
         CSR_PEAK_SPEED:    inlet_peak_speed    = data[30:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Loads a full inlet setting; unused upper bits carry random junk.
   task automatic set_inlet(input logic signed [15:0] nx, input logic signed [15:0] ny,
                            input logic signed [15:0] nz, input logic signed [31:0] cx,
                            input logic signed [31:0] cy, input logic signed [31:0] cz,
                            input logic [31:0] inv_radius_sq, input logic [30:0] peak);
      wait_idle();
      write_register(CSR_NORMAL_X, {16'($urandom), nx});
      write_register(CSR_NORMAL_Y, {16'($urandom), ny});
      write_register(CSR_NORMAL_Z, {16'($urandom), nz});
      write_register(CSR_CENTER_X, cx);
      write_register(CSR_CENTER_Y, cy);
      write_register(CSR_CENTER_Z, cz);
      write_register(CSR_INV_RADIUS_SQ, inv_radius_sq);
      write_register(CSR_PEAK_SPEED, {1'($urandom), peak});
      setting_count++;
   endtask

   // Mostly coordinates near the inlet, some full range and some extremes.
   function automatic logic signed [31:0] pick_coord();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $signed($urandom) >>> $urandom_range(11, 19);
      if (roll < 85) return $urandom;
      case ($urandom_range(0, 3))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   task automatic send_random_positions(input int count);
      for (int i = 0; i < count; i++) send_position(pick_coord(), pick_coord(), pick_coord());
   endtask

   // Random inlet setting: mostly a unit normal and a small centre.
   task automatic randomise_inlet();
      logic signed [15:0] nrm [3];
      logic signed [31:0] ctr [3];
      logic [31:0]        inv_radius_sq;
      logic [30:0]        peak;
      int                 axis;
      axis = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 2))
            0:       nrm[i] = (i == axis) ?
                              ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384) : 16'sd0;
            1:       nrm[i] = (i == 2) ? 16'sd0 : 16'sd11585;
            default: nrm[i] = 16'($urandom);
         endcase
         ctr[i] = ($urandom_range(0, 9) < 7) ? ($signed($urandom) >>> 14) : $urandom;
      end
      case ($urandom_range(0, 5))
         0:       inv_radius_sq = 0;
         1:       inv_radius_sq = 32'd65536;
         2:       inv_radius_sq = 32'd262144;
         3:       inv_radius_sq = 32'd16384;
         4:       inv_radius_sq = 32'hFFFF_FFFF;
         default: inv_radius_sq = $urandom;
      endcase
      peak = $urandom_range(0, 1) ? 31'($urandom_range(0, 1 << 22)) : 31'($urandom);
      set_inlet(nrm[0], nrm[1], nrm[2], ctr[0], ctr[1], ctr[2], inv_radius_sq, peak);
   endtask

   // Register defaults after reset: zero peak speed, so every velocity is zero.
   task automatic test_reset_defaults();
      send_position('0, '0, '0);
      send_position(32'sh0001_0000, 32'sh0001_0000, '0);
      send_position(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_8000);
      wait_idle();
   endtask

   // Radius boundary, far particles, field extremes, zero radius, saturation.
   task automatic test_directed_cases();
      set_inlet(16384, 0, 0, 0, 0, 0, 32'd65536, 31'd131072);
      // On the axis, on the rim, just past the rim, and inside off axis.
      send_position('0, '0, '0);
      send_position('0, 32'sh0001_0000, '0);
      send_position('0, 32'sh0001_0001, '0);
      send_position(32'sh0005_0000, 32'sh0000_8000, '0);
      send_position(32'sh0003_0000, '0, -32'sh0000_C000);
      // Field extremes, some far from the reference point, and all-ones fields.
      send_position('0, 32'sh8000_0000, '0);
      send_position('0, '0, 32'sh7FFF_FFFF);
      send_position(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_position(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_position('1, '1, '1);

      // Zero inverse radius puts every particle inside at full speed.
      set_inlet(-16384, 0, 0, 0, 0, 0, 32'd0, 31'd131072);
      send_position(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_position('0, '0, '0);

      // Largest peak speed with extreme normals saturates both ways.
      set_inlet(-32768, 32767, 16384, 0, 0, 0, 32'd0, 31'h7FFF_FFFF);
      send_position('0, '0, '0);
      send_position(32'sh8000_0000, '0, 32'sh7FFF_FFFF);

      // Largest inverse radius: the reference point and a point one LSB off it are inside.
      set_inlet(16384, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send_position(32'sh0012_3456, '0, '0);
      send_position(32'sh0012_3456, 32'sh0000_0001, '0);

      // Extreme centre coordinates and a zero normal.
      set_inlet(0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000,
                32'd65536, 31'd65536);
      send_position(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000);
      send_position(32'sh7FFF_FFFF, 32'sh8000_0000, '0);
      send_position('0, '0, '0);
      wait_idle();
   endtask

   // Writes beyond the register list must leave the setting untouched.
   task automatic test_unused_indexes();
      set_inlet(0, 16384, 0, 32'sh0000_4000, 32'sh0000_8000, 0, 32'd65536, 31'd98304);
      for (int i = int'(CSR_PEAK_SPEED) + 1; i < (1 << CsrIndexW); i++)
         write_register(CsrIndexW'(i), $urandom);
      send_position(32'sh0000_4000, '0, '0);
      send_position(32'sh0000_C000, 32'sh1234_5678, -32'sh0000_2000);
      send_random_positions(3);
      wait_idle();
   endtask

   // Random settings, each with a run of random positions.
   task automatic test_random_settings();
      for (int phase = 0; phase < 5; phase++) begin
         randomise_inlet();
         send_quiet  = (phase == 2);
         stall_quiet = (phase == 2);
         send_random_positions(70);
      end
      send_quiet  = 1'b0;
      stall_quiet = 1'b0;
      // One setting at the register extremes.
      set_inlet(-32768, 32767, -32768, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send_random_positions(20);
      wait_idle();
   endtask

   // Receiver holds off while requests keep coming, so the pipeline fills.
   task automatic test_full_pipeline();
      set_inlet(16384, 0, 0, 0, 0, 0, 32'd16384, 31'd200000);
      send_quiet = 1'b1;
      hold_off_request = HoldOffLen;
      send_random_positions(60);
      send_quiet = 1'b0;
      wait_idle();
   endtask

   initial begin
      error_count = 0;
      request_count = 0;
      result_count = 0;
      inside_count = 0;
      write_count = 0;
      setting_count = 1;
      backpressure_cycles = 0;
      hold_off_request = 0;
      send_quiet = 1'b0;
      stall_quiet = 1'b0;
      inlet_normal[0] = NormalXReset;
      inlet_normal[1] = '0;
      inlet_normal[2] = '0;
      for (int i = 0; i < 3; i++) inlet_center[i] = '0;
      inlet_inv_radius_sq = InvRadiusReset;
      inlet_peak_speed = '0;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_unused_indexes();
      test_random_settings();
      test_full_pipeline();

      if (velocity_q.size() != 0) begin
         $error("%0d velocity results never arrived", velocity_q.size());
         error_count++;
      end
      $display("Checked %0d results (%0d inside the inlet) for %0d requests.",
               result_count, inside_count, request_count);
      $display("Used %0d inlet settings, %0d register writes, %0d stalled request cycles.",
               setting_count, write_count, backpressure_cycles);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== parabolic_inlet_velocity.f =====
rtl/piv_pkg.sv
rtl/piv_csr.sv
rtl/piv_dist.sv
rtl/piv_ratio.sv
rtl/piv_speed.sv
rtl/parabolic_inlet_velocity.sv
test/tb_top.sv
